// ----- design/cta_pkg.sv -----
// ----------------------------------------------------------------------------
// cta_pkg: shared definitions for the centroid track associator
// Sizes, opcodes, the track table entry and the interface structs between the
// sequencer, the distance unit and the best-match tracker.
// ----------------------------------------------------------------------------
package cta_pkg;

  // Table and coordinate sizing.
  localparam int MAX_TRACKS  = 64;
  localparam int COORD_BITS  = 12;
  localparam int COLOR_COUNT = 30;

  // Fixed port widths.
  localparam int IN_COORD_W = 12;
  localparam int MD_W       = 12;
  localparam int COLOR_W    = 5;
  localparam int FRAMES_W   = 16;
  localparam int OP_W       = 2;

  localparam logic [MD_W-1:0]     MD_RESET   = MD_W'(40);
  localparam logic [FRAMES_W-1:0] FRAMES_MAX = {FRAMES_W{1'b1}};

  // Derived widths.
  localparam int IDX_W     = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;
  localparam int CNT_W     = $clog2(MAX_TRACKS + 1);
  localparam int ADDR_W    = IDX_W + 1;
  localparam int MEM_DEPTH = 2 ** ADDR_W;
  localparam int CTR_W     = COORD_BITS + 1;
  localparam int OPND_W    = (CTR_W > MD_W + 1) ? CTR_W : MD_W + 1;
  localparam int DIST_W    = 2 * OPND_W + 1;

  // Opcodes of the input channel.
  localparam logic [OP_W-1:0] OP_BOX  = 2'd0;
  localparam logic [OP_W-1:0] OP_LAST = 2'd1;
  localparam logic [OP_W-1:0] OP_END  = 2'd2;

  // One stored track: doubled center, color index and frame count.
  typedef struct packed {
    logic [CTR_W-1:0]    cx2;
    logic [CTR_W-1:0]    cy2;
    logic [COLOR_W-1:0]  color;
    logic [FRAMES_W-1:0] count;
  } track_t;

  // Request into the distance unit. The limit request carries the threshold
  // as a point so that the same unit squares it.
  typedef struct packed {
    logic                vld;
    logic                is_lim;
    logic [OPND_W-1:0]   ax;
    logic [OPND_W-1:0]   ay;
    logic [OPND_W-1:0]   bx;
    logic [OPND_W-1:0]   by;
    logic [COLOR_W-1:0]  color;
    logic [FRAMES_W-1:0] count;
  } dist_req_t;

  typedef struct packed {
    logic                vld;
    logic                is_lim;
    logic [DIST_W-1:0]   dist_sq;
    logic [COLOR_W-1:0]  color;
    logic [FRAMES_W-1:0] count;
  } dist_res_t;

  typedef struct packed {
    logic                match;
    logic [COLOR_W-1:0]  color;
    logic [FRAMES_W-1:0] count;
  } best_t;

endpackage

// ----- design/centroid_track_associator_top.sv -----
// ----------------------------------------------------------------------------
// centroid_track_associator_top: nearest centroid track associator
// Matches each detection box against the previous frame's track centers and
// reports the inherited or newly assigned track color and frame count.
// ----------------------------------------------------------------------------
// Order: a box transfer is followed by the table scan, the distance pipeline drain
//   and the decision; no new item is taken until the box has been decided.
//   The single distance unit walks the previous table one entry per cycle; a result
//   still stalled after the next search keeps the block in its decision state.
//   A frame end needs no search and is taken while idle.
// Reset: synchronous, active low; clears control, counts and color; distance 40.
module centroid_track_associator_top import cta_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  // Input channel.
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [OP_W-1:0]       in_opcode,
  input  logic [IN_COORD_W-1:0] in_left_x,
  input  logic [IN_COORD_W-1:0] in_top_y,
  input  logic [IN_COORD_W-1:0] in_right_x,
  input  logic [IN_COORD_W-1:0] in_bottom_y,
  // Result channel.
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [COLOR_W-1:0]    out_color_index,
  output logic [FRAMES_W-1:0]   out_frames_seen,
  output logic                  out_new_track,
  output logic                  out_table_full,
  // Configuration port.
  input  logic                  cfg_wr_en,
  input  logic [MD_W-1:0]       cfg_wr_data
);

  // Sequencer states.
  localparam logic [1:0] S_IDLE  = 2'd0;  // waiting for a transfer
  localparam logic [1:0] S_SCAN  = 2'd1;  // reading previous table entries
  localparam logic [1:0] S_DRAIN = 2'd2;  // distance pipeline emptying
  localparam logic [1:0] S_DONE  = 2'd3;  // deciding and storing the result

  logic [1:0]          state_r, state_nxt;
  logic [MD_W-1:0]     md_r;
  // bank_r selects the bank that holds the previous frame; the other bank
  // collects the current frame. Swapping it replaces the table copy.
  logic                bank_r, bank_nxt;
  logic [CNT_W-1:0]    prev_cnt_r, prev_cnt_nxt;
  logic [CNT_W-1:0]    cur_cnt_r, cur_cnt_nxt;
  logic [COLOR_W-1:0]  next_color_r, next_color_nxt;
  logic [CNT_W-1:0]    idx_r, idx_nxt;
  logic                rd_vld_r, rd_vld_nxt;
  logic                last_r, last_nxt;
  logic [CTR_W-1:0]    cx2_r, cx2_nxt;
  logic [CTR_W-1:0]    cy2_r, cy2_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [COLOR_W-1:0]  out_color_r, out_color_nxt;
  logic [FRAMES_W-1:0] out_frames_r, out_frames_nxt;
  logic                out_new_r, out_new_nxt;
  logic                out_full_r, out_full_nxt;

  logic                in_xfer;
  logic                is_box;
  logic                fire;
  logic                full;
  logic [CTR_W-1:0]    box_cx2, box_cy2;
  logic [FRAMES_W-1:0] res_count;
  logic [COLOR_W-1:0]  res_color;

  logic                wr_en;
  logic [ADDR_W-1:0]   wr_addr;
  logic [ADDR_W-1:0]   rd_addr;
  track_t              wr_data;
  track_t              rd_data;
  dist_req_t           dreq;
  dist_res_t           dres;
  logic                dist_busy;
  best_t               best;

  // The block takes a new item only in IDLE. A finished result may still be
  // waiting in the output register at that time.
  assign in_stall = (state_r != S_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign is_box   = (in_opcode == OP_BOX) || (in_opcode == OP_LAST);

  // Doubled centers keep full precision without a halving step.
  assign box_cx2 = CTR_W'(in_left_x[COORD_BITS-1:0]) + CTR_W'(in_right_x[COORD_BITS-1:0]);
  assign box_cy2 = CTR_W'(in_top_y[COORD_BITS-1:0]) + CTR_W'(in_bottom_y[COORD_BITS-1:0]);

  // The distance unit first squares the doubled threshold, presented as the
  // point (2*match_distance, 0) against the origin, in the transfer cycle.
  // Table entries follow one per cycle as their read data returns.
  always_comb begin
    dreq.vld    = (in_xfer && is_box) || rd_vld_r;
    dreq.is_lim = !rd_vld_r;
    if (rd_vld_r) begin
      dreq.ax = OPND_W'(cx2_r);
      dreq.ay = OPND_W'(cy2_r);
      dreq.bx = OPND_W'(rd_data.cx2);
      dreq.by = OPND_W'(rd_data.cy2);
    end else begin
      dreq.ax = OPND_W'({md_r, 1'b0});
      dreq.ay = '0;
      dreq.bx = '0;
      dreq.by = '0;
    end
    dreq.color = rd_data.color;
    dreq.count = rd_data.count;
  end

  assign rd_addr = {bank_r, idx_r[IDX_W-1:0]};

  // Decision for the box once the search has drained.
  assign fire      = (state_r == S_DONE) && (!out_valid_r || !out_stall);
  assign full      = (cur_cnt_r >= CNT_W'(MAX_TRACKS));
  assign res_color = best.match ? best.color : next_color_r;
  assign res_count = !best.match                ? FRAMES_W'(1) :
                     (best.count == FRAMES_MAX) ? best.count :
                                                  best.count + FRAMES_W'(1);

  assign wr_en   = fire && !full;
  assign wr_addr = {~bank_r, cur_cnt_r[IDX_W-1:0]};
  always_comb begin
    wr_data.cx2   = cx2_r;
    wr_data.cy2   = cy2_r;
    wr_data.color = res_color;
    wr_data.count = res_count;
  end

  always_comb begin
    state_nxt      = state_r;
    bank_nxt       = bank_r;
    prev_cnt_nxt   = prev_cnt_r;
    cur_cnt_nxt    = cur_cnt_r;
    next_color_nxt = next_color_r;
    idx_nxt        = idx_r;
    rd_vld_nxt     = 1'b0;
    last_nxt       = last_r;
    cx2_nxt        = cx2_r;
    cy2_nxt        = cy2_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_color_nxt  = out_color_r;
    out_frames_nxt = out_frames_r;
    out_new_nxt    = out_new_r;
    out_full_nxt   = out_full_r;

    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          if (is_box) begin
            cx2_nxt   = box_cx2;
            cy2_nxt   = box_cy2;
            last_nxt  = (in_opcode == OP_LAST);
            idx_nxt   = '0;
            state_nxt = S_SCAN;
          end else if (in_opcode == OP_END) begin
            // Frame end with no box: the current table becomes the previous.
            bank_nxt     = ~bank_r;
            prev_cnt_nxt = cur_cnt_r;
            cur_cnt_nxt  = '0;
          end
        end
      end
      S_SCAN: begin
        if (idx_r < prev_cnt_r) begin
          rd_vld_nxt = 1'b1;
          idx_nxt    = idx_r + CNT_W'(1);
        end else begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!rd_vld_r && !dist_busy) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (fire) begin
          out_valid_nxt  = 1'b1;
          out_color_nxt  = res_color;
          out_frames_nxt = res_count;
          out_new_nxt    = !best.match;
          out_full_nxt   = full;
          if (!best.match) begin
            next_color_nxt = (next_color_r == COLOR_W'(COLOR_COUNT - 1)) ? '0 :
                             next_color_r + COLOR_W'(1);
          end
          if (!full) begin
            cur_cnt_nxt = cur_cnt_r + CNT_W'(1);
          end
          if (last_r) begin
            // Last box of the frame: swap tables after storing this box.
            bank_nxt     = ~bank_r;
            prev_cnt_nxt = full ? cur_cnt_r : cur_cnt_r + CNT_W'(1);
            cur_cnt_nxt  = '0;
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      md_r         <= MD_RESET;
      bank_r       <= 1'b0;
      prev_cnt_r   <= '0;
      cur_cnt_r    <= '0;
      next_color_r <= '0;
      rd_vld_r     <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      bank_r       <= bank_nxt;
      prev_cnt_r   <= prev_cnt_nxt;
      cur_cnt_r    <= cur_cnt_nxt;
      next_color_r <= next_color_nxt;
      rd_vld_r     <= rd_vld_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_wr_en) begin
        md_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    last_r       <= last_nxt;
    cx2_r        <= cx2_nxt;
    cy2_r        <= cy2_nxt;
    out_color_r  <= out_color_nxt;
    out_frames_r <= out_frames_nxt;
    out_new_r    <= out_new_nxt;
    out_full_r   <= out_full_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_color_index = out_color_r;
  assign out_frames_seen = out_frames_r;
  assign out_new_track   = out_new_r;
  assign out_table_full  = out_full_r;

  cta_table u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  cta_dist u_dist (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (dreq),
    .res   (dres),
    .busy  (dist_busy)
  );

  cta_best u_best (
    .clk   (clk),
    .rst_n (rst_n),
    .clr   (in_xfer && is_box),
    .res   (dres),
    .best  (best)
  );

endmodule

// ----- design/cta_table.sv -----
// ----------------------------------------------------------------------------
// cta_table: track table memory
// Two banks of track entries, one write port and one registered read port.
// The bank bit is the top address bit.
// ----------------------------------------------------------------------------
module cta_table import cta_pkg::*; (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  track_t            wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output track_t            rd_data
);

  track_t mem [MEM_DEPTH];
  track_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ----- design/cta_dist.sv -----
// ----------------------------------------------------------------------------
// cta_dist: squared distance unit
// Three stages: absolute differences, squares, sum. Shared by the threshold
// computation and every table entry compared.
// ----------------------------------------------------------------------------
module cta_dist import cta_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  dist_req_t req,
  output dist_res_t res,
  output logic      busy
);

  logic [OPND_W-1:0]     dx, dy;
  logic [2*OPND_W-1:0]   sqx, sqy;

  logic                  s1_vld_r, s2_vld_r, s3_vld_r;
  logic                  s1_lim_r, s2_lim_r, s3_lim_r;
  logic [OPND_W-1:0]     s1_dx_r, s1_dy_r;
  logic [2*OPND_W-1:0]   s2_sqx_r, s2_sqy_r;
  logic [DIST_W-1:0]     s3_dist_r;
  logic [COLOR_W-1:0]    s1_color_r, s2_color_r, s3_color_r;
  logic [FRAMES_W-1:0]   s1_count_r, s2_count_r, s3_count_r;

  always_comb begin
    dx  = (req.ax > req.bx) ? (req.ax - req.bx) : (req.bx - req.ax);
    dy  = (req.ay > req.by) ? (req.ay - req.by) : (req.by - req.ay);
    sqx = s1_dx_r * s1_dx_r;
    sqy = s1_dy_r * s1_dy_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= req.vld;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_lim_r   <= req.is_lim;
    s1_dx_r    <= dx;
    s1_dy_r    <= dy;
    s1_color_r <= req.color;
    s1_count_r <= req.count;
    s2_lim_r   <= s1_lim_r;
    s2_sqx_r   <= sqx;
    s2_sqy_r   <= sqy;
    s2_color_r <= s1_color_r;
    s2_count_r <= s1_count_r;
    s3_lim_r   <= s2_lim_r;
    s3_dist_r  <= DIST_W'(s2_sqx_r) + DIST_W'(s2_sqy_r);
    s3_color_r <= s2_color_r;
    s3_count_r <= s2_count_r;
  end

  always_comb begin
    res.vld     = s3_vld_r;
    res.is_lim  = s3_lim_r;
    res.dist_sq = s3_dist_r;
    res.color   = s3_color_r;
    res.count   = s3_count_r;
  end

  assign busy = s1_vld_r | s2_vld_r | s3_vld_r;

endmodule

// ----- design/cta_best.sv -----
// ----------------------------------------------------------------------------
// cta_best: nearest entry tracker
// Keeps the threshold and the smallest distance seen for the current box.
// Only a strictly smaller distance replaces the best, so the first entry
// wins a tie.
// ----------------------------------------------------------------------------
module cta_best import cta_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      clr,
  input  dist_res_t res,
  output best_t     best
);

  logic                found_r;
  logic [DIST_W-1:0]   best_d_r;
  logic [DIST_W-1:0]   limit_r;
  logic [COLOR_W-1:0]  color_r;
  logic [FRAMES_W-1:0] count_r;
  logic                take;

  assign take = res.vld && !res.is_lim && (!found_r || (res.dist_sq < best_d_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
    end else if (clr) begin
      found_r <= 1'b0;
    end else if (take) begin
      found_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (res.vld && res.is_lim) begin
      limit_r <= res.dist_sq;
    end
    if (take) begin
      best_d_r <= res.dist_sq;
      color_r  <= res.color;
      count_r  <= res.count;
    end
  end

  always_comb begin
    best.match = found_r && (best_d_r < limit_r);
    best.color = color_r;
    best.count = count_r;
  end

endmodule

// ----- design/cta_chk.sv -----
// ----------------------------------------------------------------------------
// cta_chk: port level checks for the centroid track associator
// Watches the top level ports only and is attached by a bind statement.
// ----------------------------------------------------------------------------
module cta_chk import cta_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_stall,
  input logic [OP_W-1:0]       in_opcode,
  input logic                  out_valid,
  input logic                  out_stall,
  input logic [COLOR_W-1:0]    out_color_index,
  input logic [FRAMES_W-1:0]   out_frames_seen,
  input logic                  out_new_track,
  input logic                  out_table_full
);

  // A stalled result stays and holds its payload.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_color_index) &&
      $stable(out_frames_seen) && $stable(out_new_track) && $stable(out_table_full))
    else $error("stalled result changed");

  // A box transfer starts a table search, so the next item must wait.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_opcode == OP_BOX || in_opcode == OP_LAST) |=> in_stall)
    else $error("input taken during a search");

  // A new track always starts with a count of one.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_new_track |-> out_frames_seen == FRAMES_W'(1))
    else $error("new track with count other than one");

  // Colors stay within the wheel and counts never reach zero.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_color_index < COLOR_W'(COLOR_COUNT)) && (out_frames_seen != '0))
    else $error("result color or count out of range");

endmodule

bind centroid_track_associator_top cta_chk u_cta_chk (.*);
